// ----- rtl/core/rwcp_pkg.sv -----
// ---------------------------------------------------------------------------
// RIFF/WAVE chunk parser package
// Shared types, tags and status codes of the byte-serial WAV parser.
// ---------------------------------------------------------------------------
package rwcp_pkg;

  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [5:0]  FMT_KEEP = 6'd40;
  localparam logic [3:0]  HDR_LEN  = 4'd12;
  localparam int          QDEPTH   = 2;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CHUNK  = 3'd1,
    PH_FMT    = 3'd2,
    PH_DATA   = 3'd3,
    PH_SKIP   = 3'd4,
    PH_PAD    = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_HDR   = 3'd1,
    ST_NO_DATA   = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_UNSUP_FMT = 3'd4
  } status_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_REPORT = 1'b1
  } kind_t;

  typedef struct packed {
    logic        has_smp;
    logic [7:0]  smp_byte;
    logic        has_rpt;
    status_t     status;
    logic [1:0]  fmt_code;
    logic [31:0] rate;
    logic [31:0] dlen;
  } entry_t;

endpackage

// ----- rtl/core/rwcp_parser.sv -----
// ---------------------------------------------------------------------------
// RIFF/WAVE chunk parser: parsing stage
// Walks the header and chunks one byte per request and forms one queue
// entry holding the sample result, the final report, or both.
// ---------------------------------------------------------------------------
module rwcp_parser import rwcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push,
  output entry_t     entry
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] size_r, size_nxt;
  logic [15:0] ftag_r, ftag_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] dsize_r, dsize_nxt;
  logic        seen_r, seen_nxt;
  logic        bad_r, bad_nxt;
  logic [15:0] sh_fmt_r, sh_fmt_nxt;
  logic [15:0] sh_ch_r, sh_ch_nxt;
  logic [31:0] sh_rate_r, sh_rate_nxt;
  logic [15:0] sh_bits_r, sh_bits_nxt;

  logic [31:0] cnt_inc;
  logic [5:0]  keep;
  logic        ok_fmt;

  assign cnt_inc = cnt_r + 32'd1;
  assign keep    = (size_r < {26'd0, FMT_KEEP}) ? size_r[5:0] : FMT_KEEP;

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    tag_nxt     = tag_r;
    size_nxt    = size_r;
    ftag_nxt    = ftag_r;
    ch_nxt      = ch_r;
    rate_nxt    = rate_r;
    bits_nxt    = bits_r;
    dsize_nxt   = dsize_r;
    seen_nxt    = seen_r;
    bad_nxt     = bad_r;
    sh_fmt_nxt  = sh_fmt_r;
    sh_ch_nxt   = sh_ch_r;
    sh_rate_nxt = sh_rate_r;
    sh_bits_nxt = sh_bits_r;
    entry       = '0;
    ok_fmt      = 1'b0;

    unique case (phase_r)
      PH_HEADER: begin
        if (cnt_r >= 32'd8) begin
          tag_nxt = {tag_r[23:0], in_byte};
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc == {28'd0, HDR_LEN}) begin
          cnt_nxt = '0;
          if (tag_nxt == TAG_WAVE) begin
            phase_nxt = PH_CHUNK;
          end else begin
            bad_nxt   = 1'b1;
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_CHUNK: begin
        if (cnt_r < 32'd4) begin
          tag_nxt = {tag_r[23:0], in_byte};
          if (cnt_r == 32'd0) begin
            size_nxt = '0;
          end
        end else begin
          size_nxt[8*cnt_r[1:0] +: 8] = in_byte;
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 32'd8) begin
          cnt_nxt = '0;
          if (tag_nxt == TAG_FMT) begin
            sh_fmt_nxt  = '0;
            sh_ch_nxt   = '0;
            sh_rate_nxt = '0;
            sh_bits_nxt = '0;
            phase_nxt   = PH_FMT;
          end else if (tag_nxt == TAG_DATA) begin
            dsize_nxt = size_nxt;
            seen_nxt  = 1'b1;
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_SKIP;
          end
          if (size_nxt == 32'd0) begin
            phase_nxt = PH_CHUNK;
          end
        end
      end
      PH_FMT: begin
        if (cnt_r < 32'd2) begin
          sh_fmt_nxt[8*cnt_r[0] +: 8] = in_byte;
        end else if (cnt_r < 32'd4) begin
          sh_ch_nxt[8*cnt_r[0] +: 8] = in_byte;
        end else if (cnt_r < 32'd8) begin
          sh_rate_nxt[8*cnt_r[1:0] +: 8] = in_byte;
        end else if (cnt_r == 32'd14 || cnt_r == 32'd15) begin
          sh_bits_nxt[8*cnt_r[0] +: 8] = in_byte;
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc == {26'd0, keep}) begin
          if (keep >= 6'd2) begin
            ftag_nxt = sh_fmt_nxt;
          end
          if (keep >= 6'd4) begin
            ch_nxt = sh_ch_nxt;
          end
          if (keep >= 6'd8) begin
            rate_nxt = sh_rate_nxt;
          end
          if (keep >= 6'd16) begin
            bits_nxt = sh_bits_nxt;
          end
        end
        if (cnt_inc == size_r) begin
          phase_nxt = size_r[0] ? PH_PAD : PH_CHUNK;
          cnt_nxt   = '0;
        end
      end
      PH_DATA: begin
        entry.has_smp  = 1'b1;
        entry.smp_byte = in_byte;
        cnt_nxt        = cnt_inc;
        if (cnt_inc == size_r) begin
          phase_nxt = size_r[0] ? PH_PAD : PH_CHUNK;
          cnt_nxt   = '0;
        end
      end
      PH_SKIP: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc == size_r) begin
          phase_nxt = size_r[0] ? PH_PAD : PH_CHUNK;
          cnt_nxt   = '0;
        end
      end
      PH_PAD: begin
        phase_nxt = PH_CHUNK;
        cnt_nxt   = '0;
      end
      default: begin
      end
    endcase

    if (in_last) begin
      entry.has_rpt = 1'b1;
      entry.rate    = rate_nxt;
      entry.dlen    = dsize_nxt;
      ok_fmt = (ftag_nxt == 16'd1) &&
               (ch_nxt == 16'd1 || ch_nxt == 16'd2) &&
               (bits_nxt == 16'd8 || bits_nxt == 16'd16);
      priority if (phase_nxt == PH_HEADER || bad_nxt) begin
        entry.status = ST_BAD_HDR;
      end else if (phase_nxt == PH_DATA) begin
        entry.status = ST_TRUNC;
      end else if (!seen_nxt) begin
        entry.status = ST_NO_DATA;
      end else if (!ok_fmt) begin
        entry.status = ST_UNSUP_FMT;
      end else begin
        entry.status   = ST_OK;
        entry.fmt_code = {ch_nxt == 16'd2, bits_nxt == 16'd16};
      end
      phase_nxt   = PH_HEADER;
      cnt_nxt     = '0;
      tag_nxt     = '0;
      size_nxt    = '0;
      ftag_nxt    = '0;
      ch_nxt      = '0;
      rate_nxt    = '0;
      bits_nxt    = '0;
      dsize_nxt   = '0;
      seen_nxt    = 1'b0;
      bad_nxt     = 1'b0;
      sh_fmt_nxt  = '0;
      sh_ch_nxt   = '0;
      sh_rate_nxt = '0;
      sh_bits_nxt = '0;
    end
  end

  assign push = acc && (entry.has_smp || entry.has_rpt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      cnt_r     <= '0;
      tag_r     <= '0;
      size_r    <= '0;
      ftag_r    <= '0;
      ch_r      <= '0;
      rate_r    <= '0;
      bits_r    <= '0;
      dsize_r   <= '0;
      seen_r    <= 1'b0;
      bad_r     <= 1'b0;
      sh_fmt_r  <= '0;
      sh_ch_r   <= '0;
      sh_rate_r <= '0;
      sh_bits_r <= '0;
    end else if (acc) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      tag_r     <= tag_nxt;
      size_r    <= size_nxt;
      ftag_r    <= ftag_nxt;
      ch_r      <= ch_nxt;
      rate_r    <= rate_nxt;
      bits_r    <= bits_nxt;
      dsize_r   <= dsize_nxt;
      seen_r    <= seen_nxt;
      bad_r     <= bad_nxt;
      sh_fmt_r  <= sh_fmt_nxt;
      sh_ch_r   <= sh_ch_nxt;
      sh_rate_r <= sh_rate_nxt;
      sh_bits_r <= sh_bits_nxt;
    end
  end

endmodule

// ----- rtl/core/rwcp_outq.sv -----
// ---------------------------------------------------------------------------
// RIFF/WAVE chunk parser: result queue
// Two-entry queue of parser entries; each entry leaves on the result channel
// as its sample result, its report, or the sample and then the report.
// ---------------------------------------------------------------------------
module rwcp_outq import rwcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  entry_t      entry,
  output logic        room,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  localparam int CW = $clog2(QDEPTH + 1);
  localparam int PW = $clog2(QDEPTH);

  entry_t          q_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            smp_done_r;
  entry_t          head;
  logic            send_smp;
  logic            fire;
  logic            pop;

  assign head       = q_r[rd_ptr_r];
  assign room       = (count_r < CW'(QDEPTH));
  assign out_tvalid = (count_r != '0);
  assign send_smp   = head.has_smp && !smp_done_r;
  assign fire       = out_tvalid && out_tready;
  assign pop        = fire && (!send_smp || !head.has_rpt);

  assign out_tuser = send_smp ? KIND_SAMPLE : KIND_REPORT;
  assign out_tlast = !send_smp;
  assign out_tdata = send_smp ? {72'd0, head.smp_byte}
                              : {3'd0, head.dlen, head.rate, head.fmt_code,
                                 head.status, 8'd0};

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
      smp_done_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
      if (pop) begin
        smp_done_r <= 1'b0;
      end else if (fire && send_smp) begin
        smp_done_r <= 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QDEPTH))
    else $error("result queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> room)
    else $error("entry written into a full result queue");

  a_split_entry: assert property (@(posedge clk) disable iff (!rst_n)
    smp_done_r |-> (out_tvalid && head.has_smp && head.has_rpt))
    else $error("half-sent entry without a pending report");

endmodule

// ----- rtl/core/riff_wave_chunk_parser_unit.sv -----
// ---------------------------------------------------------------------------
// RIFF/WAVE chunk parser
// Byte-serial WAV parser that passes data-chunk bytes out as samples and
// gives a final report on the last byte of the file.
// ---------------------------------------------------------------------------
// The block takes one file byte per cycle while the queue has room and
// holds no clearing pass after reset. A byte is parsed in the cycle it is
// accepted and its results go into a two-entry queue that decouples the
// two sides. The last byte of a file that falls inside a data chunk gives
// two results, a sample and then the report, which leave one after the
// other; every other byte gives at most one. The input pauses only while
// both queue entries are waiting.
module riff_wave_chunk_parser_unit import rwcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte [7:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // sample_byte [7:0], status [10:8],
                                  // format_code [12:11], sample_rate [44:13],
                                  // data_length [76:45], zero [79:77]
  output logic        out_tuser,  // out_kind [0]
  output logic        out_tlast
);

  logic   acc;
  logic   push;
  logic   room;
  entry_t entry;

  assign in_tready = room;
  assign acc       = in_tvalid && in_tready;

  rwcp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .push    (push),
    .entry   (entry)
  );

  rwcp_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .entry      (entry),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// RIFF/WAVE chunk parser testbench
// Feeds whole and cut-short WAV files byte by byte, predicts every sample
// byte and final report in a local parser model, and compares each result
// with the oldest prediction while both sides idle at random, save one stretch.
// ---------------------------------------------------------------------------
module tb_top;
  import rwcp_pkg::*;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
  localparam logic [15:0] PCM_TAG  = 16'd1;

  typedef struct {
    kind_t       kind;
    logic [7:0]  smp;
    status_t     st;
    logic [1:0]  fmt_code;
    logic [31:0] rate;
    logic [31:0] dlen;
    logic        last;
  } wav_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  riff_wave_chunk_parser_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  wav_result_t expected_results[$];
  logic [7:0]  file_bytes[$];
  logic        no_idle = 1'b0;
  int          mismatch_count = 0;
  int          bytes_sent = 0;
  int          files_sent = 0;
  int          samples_checked = 0;
  int          reports_checked = 0;

  // Parser model state.
  phase_t      m_phase;
  logic [31:0] m_count, m_tag, m_size, m_rate, m_dsize;
  logic [15:0] m_fmt, m_chans, m_bits;
  logic        m_seen_data, m_bad_hdr;
  logic [15:0] sh_fmt, sh_chans, sh_bits;
  logic [31:0] sh_rate;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic clear_parser();
    m_phase = PH_HEADER;
    m_count = '0; m_tag = '0; m_size = '0; m_rate = '0; m_dsize = '0;
    m_fmt = '0; m_chans = '0; m_bits = '0;
    m_seen_data = 1'b0; m_bad_hdr = 1'b0;
    sh_fmt = '0; sh_chans = '0; sh_bits = '0; sh_rate = '0;
  endtask

  task automatic end_body();
    if (m_size[0]) m_phase = PH_PAD;
    else m_phase = PH_CHUNK;
    m_count = '0;
  endtask

  task automatic end_chunk_header();
    m_count = '0;
    if (m_tag == TAG_FMT) begin
      sh_fmt = '0; sh_chans = '0; sh_rate = '0; sh_bits = '0;
      m_phase = PH_FMT;
    end else if (m_tag == TAG_DATA) begin
      m_dsize = m_size;
      m_seen_data = 1'b1;
      m_phase = PH_DATA;
    end else begin
      m_phase = PH_SKIP;
    end
    if (m_size == 0) end_body();
  endtask

  task automatic take_fmt_byte(input logic [7:0] b);
    logic [31:0] i;
    logic [31:0] keep;
    i = m_count;
    keep = (m_size < 32'(FMT_KEEP)) ? m_size : 32'(FMT_KEEP);
    if (i < 2) sh_fmt |= {8'd0, b} << (8 * i);
    else if (i < 4) sh_chans |= {8'd0, b} << (8 * (i - 2));
    else if (i < 8) sh_rate |= {24'd0, b} << (8 * (i - 4));
    else if (i == 14 || i == 15) sh_bits |= {8'd0, b} << (8 * (i - 14));
    m_count = i + 1;
    if (m_count == keep) begin
      if (keep >= 2) m_fmt = sh_fmt;
      if (keep >= 4) m_chans = sh_chans;
      if (keep >= 8) m_rate = sh_rate;
      if (keep >= 16) m_bits = sh_bits;
    end
    if (m_count == m_size) end_body();
  endtask

  task automatic parse_file_byte(input logic [7:0] b, input logic last);
    wav_result_t r;
    r = '{KIND_SAMPLE, 8'd0, ST_OK, 2'd0, 32'd0, 32'd0, 1'b0};
    case (m_phase)
      PH_HEADER: begin
        if (m_count >= 8) m_tag = {m_tag[23:0], b};
        m_count++;
        if (m_count == 32'(HDR_LEN)) begin
          m_count = '0;
          if (m_tag == TAG_WAVE) begin
            m_phase = PH_CHUNK;
          end else begin
            m_bad_hdr = 1'b1;
            m_phase = PH_DONE;
          end
        end
      end
      PH_CHUNK: begin
        if (m_count < 4) begin
          m_tag = {m_tag[23:0], b};
          if (m_count == 0) m_size = '0;
        end else begin
          m_size |= {24'd0, b} << (8 * ((m_count - 4) & 3));
        end
        m_count++;
        if (m_count >= 8) end_chunk_header();
      end
      PH_FMT: take_fmt_byte(b);
      PH_DATA: begin
        r.smp = b;
        expected_results.push_back(r);
        m_count++;
        if (m_count == m_size) end_body();
      end
      PH_SKIP: begin
        m_count++;
        if (m_count == m_size) end_body();
      end
      PH_PAD: begin
        m_phase = PH_CHUNK;
        m_count = '0;
      end
      default: ;
    endcase
    if (last) begin
      r = '{KIND_REPORT, 8'd0, ST_OK, 2'd0, m_rate, m_dsize, 1'b1};
      if (m_phase == PH_HEADER || m_bad_hdr) r.st = ST_BAD_HDR;
      else if (m_phase == PH_DATA) r.st = ST_TRUNC;
      else if (!m_seen_data) r.st = ST_NO_DATA;
      else if (m_fmt != PCM_TAG || (m_chans != 1 && m_chans != 2) ||
               (m_bits != 8 && m_bits != 16)) r.st = ST_UNSUP_FMT;
      else r.fmt_code = {m_chans == 2, m_bits == 16};
      expected_results.push_back(r);
      clear_parser();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_result();
    wav_result_t e;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result, data %h kind %b", out_tdata, out_tuser));
      return;
    end
    e = expected_results.pop_front();
    if (e.kind == KIND_SAMPLE) samples_checked++;
    else reports_checked++;
    if (out_tuser !== e.kind)
      report_mismatch($sformatf("kind %b, expected %b", out_tuser, e.kind));
    if (out_tdata[7:0] !== e.smp)
      report_mismatch($sformatf("sample %h, expected %h", out_tdata[7:0], e.smp));
    if (out_tdata[10:8] !== e.st)
      report_mismatch($sformatf("status %0d, expected %0d", out_tdata[10:8], e.st));
    if (out_tdata[12:11] !== e.fmt_code)
      report_mismatch($sformatf("format code %0d, expected %0d", out_tdata[12:11],
                                e.fmt_code));
    if (out_tdata[44:13] !== e.rate)
      report_mismatch($sformatf("rate %h, expected %h", out_tdata[44:13], e.rate));
    if (out_tdata[76:45] !== e.dlen)
      report_mismatch($sformatf("data length %h, expected %h", out_tdata[76:45], e.dlen));
    if (out_tdata[79:77] !== 3'd0)
      report_mismatch($sformatf("padding bits %b not zero", out_tdata[79:77]));
    if (out_tlast !== e.last)
      report_mismatch($sformatf("last %b, expected %b", out_tlast, e.last));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
    out_tready <= no_idle || ($urandom_range(99) >= 29);
  end

  task automatic send_request(input logic [7:0] b, input logic last);
    while (!no_idle && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    parse_file_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      send_request(file_bytes[i], i == file_bytes.size() - 1);
    files_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic put_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(t[8*i +: 8]);
  endtask

  task automatic put_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic put_wave_header(input logic [31:0] form);
    file_bytes.delete();
    put_tag(TAG_RIFF);
    put_le32($urandom);
    put_tag(form);
  endtask

  // Random body bytes, then a pad byte when the size is odd.
  task automatic put_chunk(input logic [31:0] tag, input int size);
    put_tag(tag);
    put_le32(size);
    for (int i = 0; i < size; i++) file_bytes.push_back($urandom_range(255));
    if (size % 2) file_bytes.push_back($urandom_range(255));
  endtask

  task automatic put_fmt(input int size, input logic [15:0] ftag, input logic [15:0] chans,
                         input logic [31:0] rate, input logic [15:0] bits);
    logic [7:0] b;
    put_tag(TAG_FMT);
    put_le32(size);
    for (int i = 0; i < size; i++) begin
      b = $urandom_range(255);
      if (i < 2) b = ftag[8*i +: 8];
      else if (i < 4) b = chans[8*(i-2) +: 8];
      else if (i < 8) b = rate[8*(i-4) +: 8];
      else if (i == 14 || i == 15) b = bits[8*(i-14) +: 8];
      file_bytes.push_back(b);
    end
    if (size % 2) file_bytes.push_back($urandom_range(255));
  endtask

  task automatic test_header_cases();
    // A file that ends inside the header, then one with a wrong form type.
    file_bytes = '{8'h00, 8'hFF};
    send_file();
    put_wave_header(32'h5741_5658);
    put_chunk(TAG_DATA, 1);
    send_file();
  endtask

  task automatic test_good_files();
    // Two data chunks: the report carries the size of the second, empty one.
    put_wave_header(TAG_WAVE);
    put_fmt(16, PCM_TAG, 16'd2, 32'hFFFF_FFFF, 16'd16);
    put_tag(TAG_DATA);
    put_le32(3);
    file_bytes = {file_bytes, 8'hFF, 8'h00, 8'h80, 8'h55};
    put_chunk(TAG_DATA, 0);
    send_file();
    put_wave_header(TAG_WAVE);
    put_chunk(TAG_LIST, 3);
    put_fmt(44, PCM_TAG, 16'd1, 32'd44100, 16'd16);
    put_chunk(TAG_DATA, 2);
    // A short fmt chunk keeps the bit depth of the earlier one.
    put_fmt(10, PCM_TAG, 16'd2, 32'd8000, 16'd8);
    send_file();
  endtask

  task automatic test_fmt_cases();
    put_wave_header(TAG_WAVE);
    put_fmt(16, PCM_TAG, 16'd1, 32'd22050, 16'd8);
    send_file();
    put_wave_header(TAG_WAVE);
    put_fmt(18, 16'd3, 16'd2, 32'd48000, 16'd24);
    put_chunk(TAG_DATA, 1);
    send_file();
    // The file ends before the fmt fields are committed.
    put_wave_header(TAG_WAVE);
    put_fmt(16, PCM_TAG, 16'd1, 32'd8000, 16'd8);
    repeat (11) void'(file_bytes.pop_back());
    send_file();
  endtask

  task automatic test_truncation();
    put_wave_header(TAG_WAVE);
    put_fmt(16, PCM_TAG, 16'd1, 32'd8000, 16'd8);
    put_tag(TAG_DATA);
    put_le32(32'h0000_0100);
    file_bytes = {file_bytes, 8'h01, 8'h02, 8'h03, 8'h04};
    send_file();
    // Skipped chunk of the largest odd size, ended early.
    put_wave_header(TAG_WAVE);
    put_chunk(TAG_DATA, 2);
    put_tag(TAG_LIST);
    put_le32(32'hFFFF_FFFF);
    file_bytes = {file_bytes, 8'hAA, 8'h00, 8'hFF};
    send_file();
  endtask

  task automatic build_random_file();
    int     nchunks, pick, size, cut;
    logic   open_end;
    open_end = 1'b0;
    if ($urandom_range(99) < 6) begin
      file_bytes.delete();
      repeat ($urandom_range(1, 40)) file_bytes.push_back($urandom_range(255));
      return;
    end
    put_wave_header(($urandom_range(99) < 6) ? $urandom : TAG_WAVE);
    nchunks = $urandom_range(0, 4);
    for (int c = 0; c < nchunks && !open_end; c++) begin
      pick = (c == 0) ? $urandom_range(99) / 2 : $urandom_range(99);
      if (pick < 40) begin
        case ($urandom_range(9))
          5, 6: size = $urandom_range(0, 40);
          7, 8: size = $urandom_range(41, 50);
          9: size = 18;
          default: size = 16;
        endcase
        put_fmt(size,
                ($urandom_range(99) < 85) ? PCM_TAG : 16'($urandom),
                ($urandom_range(99) < 85) ? 16'($urandom_range(1, 2)) : 16'($urandom),
                $urandom,
                ($urandom_range(99) < 85) ? 16'($urandom_range(1, 2) * 8) : 16'($urandom));
      end else if (pick < 80 || $urandom_range(11) != 0) begin
        put_chunk((pick < 80) ? TAG_DATA : $urandom, $urandom_range(0, 24));
      end else begin
        // Huge size: the file never reaches the end of the body.
        put_tag(($urandom_range(1)) ? TAG_DATA : TAG_LIST);
        put_le32(($urandom_range(3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h100));
        repeat ($urandom_range(0, 6)) file_bytes.push_back($urandom_range(255));
        open_end = 1'b1;
      end
    end
    if ($urandom_range(99) < 12) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endtask

  task automatic test_random_files(input int byte_budget);
    int stop_at;
    stop_at = bytes_sent + byte_budget;
    while (bytes_sent < stop_at) begin
      build_random_file();
      if ($urandom_range(7) == 0) wait_drained();
      send_file();
    end
  endtask

  task automatic test_no_idle_stretch();
    wait_drained();
    no_idle = 1'b1;
    test_random_files(350);
    no_idle = 1'b0;
  endtask

  initial begin
    clear_parser();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_header_cases();
    test_good_files();
    test_fmt_cases();
    test_truncation();
    test_random_files(550);
    test_no_idle_stretch();
    test_random_files(550);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d files, %0d bytes: header, fmt, data, skip and pad paths,",
             files_sent, bytes_sent);
    $display("with %0d sample bytes and %0d final reports compared.",
             samples_checked, reports_checked);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
